>>> hw/rtl/stq_pkg.sv
// stq_pkg: shared types, codes and a result helper for the sorted timer queue
// no dependencies; imported by stq_ctrl, stq_dp and sorted_timer_queue
`default_nettype none
package stq_pkg;

  localparam int NUM_TIMERS = 32;
  localparam int IDX_W      = 5;
  localparam int LINK_W     = 6;
  localparam logic [LINK_W-1:0] LINK_EMPTY = LINK_W'(NUM_TIMERS);
  localparam logic [31:0] ALL_ONES = 32'hffff_ffff;

  localparam logic [2:0] REQ_TICK  = 3'd0;
  localparam logic [2:0] REQ_ALLOC = 3'd1;
  localparam logic [2:0] REQ_FREE  = 3'd2;
  localparam logic [2:0] REQ_BIND  = 3'd3;
  localparam logic [2:0] REQ_ARM   = 3'd4;

  localparam logic [1:0] KIND_EXPIRY = 2'd0;
  localparam logic [1:0] KIND_TSW    = 2'd1;
  localparam logic [1:0] KIND_STATUS = 2'd2;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NO_FREE = 2'd1;
  localparam logic [1:0] ST_WRONG   = 2'd2;

  // datapath commands
  localparam int CMD_W = 5;
  localparam logic [CMD_W-1:0] CMD_NOP        = 5'd0;
  localparam logic [CMD_W-1:0] CMD_LOAD       = 5'd1;
  localparam logic [CMD_W-1:0] CMD_TICK       = 5'd2;
  localparam logic [CMD_W-1:0] CMD_TEXP       = 5'd3;
  localparam logic [CMD_W-1:0] CMD_TFIN       = 5'd4;
  localparam logic [CMD_W-1:0] CMD_TSW        = 5'd5;
  localparam logic [CMD_W-1:0] CMD_SCAN_INIT  = 5'd6;
  localparam logic [CMD_W-1:0] CMD_SCAN_NEXT  = 5'd7;
  localparam logic [CMD_W-1:0] CMD_ALLOC_TAKE = 5'd8;
  localparam logic [CMD_W-1:0] CMD_ALLOC_NONE = 5'd9;
  localparam logic [CMD_W-1:0] CMD_FREE       = 5'd10;
  localparam logic [CMD_W-1:0] CMD_BIND       = 5'd11;
  localparam logic [CMD_W-1:0] CMD_ARM_BAD    = 5'd12;
  localparam logic [CMD_W-1:0] CMD_ARM_FRONT  = 5'd13;
  localparam logic [CMD_W-1:0] CMD_ARM_START  = 5'd14;
  localparam logic [CMD_W-1:0] CMD_ARM_NEXT   = 5'd15;
  localparam logic [CMD_W-1:0] CMD_ARM_LAST   = 5'd16;
  localparam logic [CMD_W-1:0] CMD_ARM_HERE   = 5'd17;
  localparam logic [CMD_W-1:0] CMD_ARM_ADV    = 5'd18;
  localparam logic [CMD_W-1:0] CMD_ARM_SELF   = 5'd19;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [4:0]  timer_index;
    logic [3:0]  dest_id;
    logic [31:0] message;
    logic [31:0] delay;
  } req_t;

  typedef struct packed {
    logic [1:0]  result_kind;
    logic [1:0]  status;
    logic [4:0]  out_index;
    logic [3:0]  out_dest;
    logic [31:0] out_message;
    logic        last;
  } res_t;

  // datapath status seen by the controller
  typedef struct packed {
    logic [2:0] req_type;
    logic       idx_alloc;
    logic       arm_front;
    logic       scan_free;
    logic       scan_end;
    logic       due;
    logic       cur_empty;
    logic       cur_due;
    logic       link_empty;
    logic       dl_le;
    logic       ts_flag;
    logic       buf_valid;
  } dp_stat_t;

  function automatic res_t mk_status(input logic [1:0] st, input logic [IDX_W-1:0] idx);
    res_t r;
    r.result_kind = KIND_STATUS;
    r.status      = st;
    r.out_index   = idx;
    r.out_dest    = 4'd0;
    r.out_message = 32'd0;
    r.last        = 1'b1;
    return r;
  endfunction

endpackage
`default_nettype wire

>>> hw/rtl/stq_dp.sv
// stq_dp: timer pool datapath, entry memories, sorted list registers and result register
// depends on stq_pkg; driven by commands from stq_ctrl
`default_nettype none
module stq_dp
  import stq_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic [CMD_W-1:0] cmd,
  input  wire req_t             req_in,
  input  wire logic             cfg_we,
  input  wire logic [5:0]       cfg_wdata,
  output dp_stat_t              stat,
  output logic                  res_valid,
  output res_t                  res
);

  logic [31:0] dl_mem   [NUM_TIMERS];
  logic [31:0] msg_mem  [NUM_TIMERS];
  logic [3:0]  dest_mem [NUM_TIMERS];
  logic [LINK_W-1:0] link_mem [NUM_TIMERS];

  logic [31:0] dl_rd, msg_rd;
  logic [3:0]  dest_rd;
  logic [LINK_W-1:0] link_rd;

  req_t req;
  logic [31:0] tick_count, earliest, dnew;
  logic [LINK_W-1:0] head, cur, prev;
  logic [IDX_W-1:0] scan, ts_idx;
  logic [5:0] tst;
  logic ts_flag, buf_valid;
  res_t buf_res;
  logic [NUM_TIMERS-1:0] alloc_q, pend_q;

  logic [31:0] dnew_c;
  logic [IDX_W-1:0] rd_addr, idx;
  logic res_fire;

  assign idx    = req.timer_index;
  assign dnew_c = req.delay + tick_count;

  always_comb begin
    unique case (cmd)
      CMD_TICK, CMD_ARM_START: rd_addr = head[IDX_W-1:0];
      CMD_TEXP, CMD_ARM_NEXT:  rd_addr = link_rd[IDX_W-1:0];
      default:                 rd_addr = cur[IDX_W-1:0];
    endcase
  end

  // commands that put a result on the output register
  always_comb begin
    unique case (cmd)
      CMD_TEXP:       res_fire = buf_valid;
      CMD_TFIN:       res_fire = buf_valid || ts_flag;
      CMD_TSW, CMD_ALLOC_TAKE, CMD_ALLOC_NONE, CMD_FREE, CMD_BIND,
      CMD_ARM_BAD, CMD_ARM_FRONT, CMD_ARM_SELF: res_fire = 1'b1;
      default:        res_fire = 1'b0;
    endcase
  end

  // entry memories, registered read at one shared address
  always_ff @(posedge clk) begin
    dl_rd   <= dl_mem[rd_addr];
    msg_rd  <= msg_mem[rd_addr];
    dest_rd <= dest_mem[rd_addr];
    link_rd <= link_mem[rd_addr];
    if (cmd == CMD_ARM_FRONT || cmd == CMD_ARM_START) begin
      dl_mem[idx] <= dnew_c;
    end
    if (cmd == CMD_BIND) begin
      msg_mem[idx]  <= req.message;
      dest_mem[idx] <= req.dest_id;
    end
    if (cmd == CMD_ARM_FRONT) begin
      link_mem[idx] <= head;
    end else if (cmd == CMD_ARM_LAST || cmd == CMD_ARM_HERE) begin
      link_mem[prev[IDX_W-1:0]] <= LINK_W'(idx);
    end else if (cmd == CMD_ARM_SELF) begin
      link_mem[idx] <= cur;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_count <= 32'd0;
      earliest   <= ALL_ONES;
      head       <= LINK_EMPTY;
      alloc_q    <= '0;
      pend_q     <= '0;
      tst        <= 6'd32;
      ts_flag    <= 1'b0;
      buf_valid  <= 1'b0;
      res_valid  <= 1'b0;
    end else begin
      res_valid <= res_fire;
      if (cfg_we) begin
        tst <= cfg_wdata;
      end
      unique case (cmd)
        CMD_LOAD: req <= req_in;
        CMD_TICK: begin
          tick_count <= tick_count + 32'd1;
          cur        <= head;
          ts_flag    <= 1'b0;
          buf_valid  <= 1'b0;
        end
        CMD_TEXP: begin
          alloc_q[cur[IDX_W-1:0]] <= 1'b1;
          pend_q[cur[IDX_W-1:0]]  <= 1'b0;
          if (buf_valid) begin
            res <= buf_res;
          end
          if (cur == tst) begin
            ts_flag   <= 1'b1;
            ts_idx    <= cur[IDX_W-1:0];
            buf_valid <= 1'b0;
          end else begin
            buf_res.result_kind <= KIND_EXPIRY;
            buf_res.status      <= ST_OK;
            buf_res.out_index   <= cur[IDX_W-1:0];
            buf_res.out_dest    <= dest_rd;
            buf_res.out_message <= msg_rd;
            buf_res.last        <= 1'b0;
            buf_valid           <= 1'b1;
          end
          cur <= link_rd;
        end
        CMD_TFIN: begin
          head     <= cur;
          earliest <= cur[LINK_W-1] ? ALL_ONES : dl_rd;
          if (buf_valid) begin
            res <= '{buf_res.result_kind, buf_res.status, buf_res.out_index,
                     buf_res.out_dest, buf_res.out_message, !ts_flag};
          end else if (ts_flag) begin
            res <= '{KIND_TSW, ST_OK, ts_idx, 4'd0, 32'd0, 1'b1};
          end
        end
        CMD_TSW: begin
          res <= '{KIND_TSW, ST_OK, ts_idx, 4'd0, 32'd0, 1'b1};
        end
        CMD_SCAN_INIT: scan <= '0;
        CMD_SCAN_NEXT: scan <= scan + 1'b1;
        CMD_ALLOC_TAKE: begin
          alloc_q[scan] <= 1'b1;
          res           <= mk_status(ST_OK, scan);
        end
        CMD_ALLOC_NONE: begin
          res <= mk_status(ST_NO_FREE, '0);
        end
        CMD_FREE: begin
          if (pend_q[idx]) begin
            res <= mk_status(ST_WRONG, idx);
          end else begin
            alloc_q[idx] <= 1'b0;
            res          <= mk_status(ST_OK, idx);
          end
        end
        CMD_BIND: begin
          res <= mk_status(ST_OK, idx);
        end
        CMD_ARM_BAD: begin
          res <= mk_status(ST_WRONG, idx);
        end
        CMD_ARM_FRONT: begin
          alloc_q[idx] <= 1'b0;
          pend_q[idx]  <= 1'b1;
          head         <= LINK_W'(idx);
          earliest     <= dnew_c;
          res          <= mk_status(ST_OK, idx);
        end
        CMD_ARM_START: begin
          alloc_q[idx] <= 1'b0;
          pend_q[idx]  <= 1'b1;
          dnew         <= dnew_c;
          prev         <= head;
        end
        CMD_ARM_NEXT, CMD_ARM_LAST: cur <= link_rd;
        CMD_ARM_ADV: prev <= cur;
        CMD_ARM_SELF: begin
          res <= mk_status(ST_OK, idx);
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    stat.req_type   = req.req_type;
    stat.idx_alloc  = alloc_q[idx];
    stat.arm_front  = head[LINK_W-1] || (dnew_c <= earliest);
    stat.scan_free  = !alloc_q[scan] && !pend_q[scan];
    stat.scan_end   = (scan == IDX_W'(NUM_TIMERS - 1));
    stat.due        = earliest <= tick_count;
    stat.cur_empty  = cur[LINK_W-1];
    stat.cur_due    = dl_rd <= tick_count;
    stat.link_empty = link_rd[LINK_W-1];
    stat.dl_le      = dnew <= dl_rd;
    stat.ts_flag    = ts_flag;
    stat.buf_valid  = buf_valid;
  end

  a_state_excl: assert property (@(posedge clk) disable iff (rst) (alloc_q & pend_q) == '0)
    else $error("timer both allocated and pending");
  a_empty_ones: assert property (@(posedge clk) disable iff (rst)
    head == LINK_EMPTY |-> earliest == ALL_ONES)
    else $error("empty list with finite earliest deadline");
  a_kind: assert property (@(posedge clk) disable iff (rst) res_valid |-> res.result_kind != 2'd3)
    else $error("bad result kind");

endmodule
`default_nettype wire

>>> hw/rtl/stq_ctrl.sv
// stq_ctrl: request sequencer for the sorted timer queue
// depends on stq_pkg; issues commands to stq_dp and reads its status
`default_nettype none
module stq_ctrl
  import stq_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire dp_stat_t         stat,
  output logic                  busy,
  output logic [CMD_W-1:0]      cmd
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_DECODE = 4'd1;
  localparam logic [3:0] S_TCHK   = 4'd2;
  localparam logic [3:0] S_TEVAL  = 4'd3;
  localparam logic [3:0] S_TSW    = 4'd4;
  localparam logic [3:0] S_SCAN   = 4'd5;
  localparam logic [3:0] S_ARM_RD = 4'd6;
  localparam logic [3:0] S_ARM_CMP = 4'd7;
  localparam logic [3:0] S_ARM_SELF = 4'd8;

  logic [3:0] state, state_next;

  assign busy = (state != S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = CMD_NOP;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd        = CMD_LOAD;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        state_next = S_IDLE;
        unique case (stat.req_type)
          REQ_TICK: begin
            cmd        = CMD_TICK;
            state_next = S_TCHK;
          end
          REQ_ALLOC: begin
            cmd        = CMD_SCAN_INIT;
            state_next = S_SCAN;
          end
          REQ_FREE: cmd = CMD_FREE;
          REQ_BIND: cmd = CMD_BIND;
          REQ_ARM: begin
            if (!stat.idx_alloc) begin
              cmd = CMD_ARM_BAD;
            end else if (stat.arm_front) begin
              cmd = CMD_ARM_FRONT;
            end else begin
              cmd        = CMD_ARM_START;
              state_next = S_ARM_RD;
            end
          end
          default: cmd = CMD_NOP;
        endcase
      end
      S_TCHK, S_TEVAL: begin
        if (state == S_TCHK && !stat.due) begin
          state_next = S_IDLE;
        end else if (stat.cur_empty || !stat.cur_due) begin
          cmd        = CMD_TFIN;
          state_next = (stat.ts_flag && stat.buf_valid) ? S_TSW : S_IDLE;
        end else begin
          cmd        = CMD_TEXP;
          state_next = S_TEVAL;
        end
      end
      S_TSW: begin
        cmd        = CMD_TSW;
        state_next = S_IDLE;
      end
      S_SCAN: begin
        priority if (stat.scan_free) begin
          cmd        = CMD_ALLOC_TAKE;
          state_next = S_IDLE;
        end else if (stat.scan_end) begin
          cmd        = CMD_ALLOC_NONE;
          state_next = S_IDLE;
        end else begin
          cmd = CMD_SCAN_NEXT;
        end
      end
      S_ARM_RD: begin
        if (stat.link_empty) begin
          cmd        = CMD_ARM_LAST;
          state_next = S_ARM_SELF;
        end else begin
          cmd        = CMD_ARM_NEXT;
          state_next = S_ARM_CMP;
        end
      end
      S_ARM_CMP: begin
        if (stat.dl_le) begin
          cmd        = CMD_ARM_HERE;
          state_next = S_ARM_SELF;
        end else begin
          cmd        = CMD_ARM_ADV;
          state_next = S_ARM_RD;
        end
      end
      S_ARM_SELF: begin
        cmd        = CMD_ARM_SELF;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  a_load: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE && start) |=> state == S_DECODE)
    else $error("accepted request not decoded");
  a_busy: assert property (@(posedge clk) disable iff (rst)
    cmd == CMD_LOAD |-> !busy)
    else $error("request loaded while busy");
  a_tsw: assert property (@(posedge clk) disable iff (rst)
    state == S_TSW |-> $past(cmd) == CMD_TFIN)
    else $error("task switch result out of sequence");

endmodule
`default_nettype wire

>>> hw/rtl/sorted_timer_queue.sv
// sorted_timer_queue: top level of the deadline-ordered one-shot timer pool
// depends on stq_pkg, stq_ctrl and stq_dp
//
//   channel   | signals                 | handshake
//   request   | start, busy, req        | taken when start high and busy low
//   result    | result_valid, result    | one-cycle strobe, cannot be held off
//   config    | cfg_we, cfg_wdata       | task switch timer index, written on cfg_we
//
// steps: a request is loaded, then decoded; free, bind and front arms finish in the decode step;
//   allocate scans one timer per cycle (up to 32); arm walks the list reading each entry's link
//   and then its deadline; a tick checks the earliest deadline, then walks one expired timer per cycle
// status results leave from an output register in the cycle after the step that makes them;
//   an expiry waits in a holding register until the next walk step, then goes out likewise
// reset clears tick count, list head, timer states and config; entry memories are not cleared
// busy stays high through the walk; results cannot be stalled by the receiver
`default_nettype none
module sorted_timer_queue
  import stq_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       start,
  output logic            busy,
  input  wire req_t       req,
  input  wire logic       cfg_we,
  input  wire logic [5:0] cfg_wdata,
  output logic            result_valid,
  output res_t            result
);

  // command and status between sequencer and datapath
  logic [CMD_W-1:0] cmd;
  dp_stat_t         stat;

  stq_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .busy  (busy),
    .cmd   (cmd)
  );

  stq_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .req_in    (req),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .stat      (stat),
    .res_valid (result_valid),
    .res       (result)
  );

endmodule
`default_nettype wire
